// ----- design/washer_tick_timer_motor_reversal_core_macros.svh -----
// ---------------------------------------------------------------------------
// Washer tick timer assertion macros
// Shared assertion forms for the tick timer core, clocked on clk_i and
// disabled while rst_ni is low.
// ---------------------------------------------------------------------------
`ifndef WASHER_TICK_TIMER_MOTOR_REVERSAL_CORE_MACROS_SVH
`define WASHER_TICK_TIMER_MOTOR_REVERSAL_CORE_MACROS_SVH

// Same-cycle implication.
`define WTTMR_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define WTTMR_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- design/wttmr_pkg.sv -----
// ---------------------------------------------------------------------------
// Washer tick timer package
// Types, register indexes, run state codes and reset values.
// ---------------------------------------------------------------------------
package wttmr_pkg;

  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned CntW    = 8;
  localparam int unsigned BitCntW = 3;

  // Configuration register indexes
  localparam logic [CfgIdxW-1:0] REG_REVERSE_PERIOD   = 3'd0;
  localparam logic [CfgIdxW-1:0] REG_TICKS_PER_MINUTE = 3'd1;
  localparam logic [CfgIdxW-1:0] REG_IDLE_LIMIT       = 3'd2;
  localparam logic [CfgIdxW-1:0] REG_FILL_LIMIT       = 3'd3;
  localparam logic [CfgIdxW-1:0] REG_DRAIN_LIMIT      = 3'd4;

  // Reset values of the configuration registers
  localparam logic [CntW-1:0] RST_REVERSE_PERIOD   = 8'd10;
  localparam logic [CntW-1:0] RST_TICKS_PER_MINUTE = 8'd120;
  localparam logic [CntW-1:0] RST_IDLE_LIMIT       = 8'd10;
  localparam logic [CntW-1:0] RST_FILL_LIMIT       = 8'd10;
  localparam logic [CntW-1:0] RST_DRAIN_LIMIT      = 8'd5;

  // Run state codes
  localparam logic [1:0] RUN_ACTIVE  = 2'd0;
  localparam logic [1:0] RUN_IDLE    = 2'd1;
  localparam logic [1:0] RUN_SUSPEND = 2'd2;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_DIV  = 3'b010,
    ST_DONE = 3'b100
  } state_e;

endpackage

// ----- design/washer_tick_timer_motor_reversal_core.sv -----
// ---------------------------------------------------------------------------
// Washer tick timer with low-speed motor reversal
// Half-second tick processor: minute counters, motor stop/reverse control
// and latched power-off / fault-reset requests.
// ---------------------------------------------------------------------------
// Each input request is one half-second tick. The core takes no new tick
// until it is done with the last one: it captures the request, runs a
// shared 9-bit compare-and-subtract unit that produces the tick count
// modulo reverse_period one dividend bit at a time, and then commits the
// new state and presents the result. in_stall_o is high from the first
// divide step until the commit. The commit waits while an earlier result
// is still stalled at the output. The result fields are driven straight
// from the state registers, which only change at a commit. Configuration
// writes belong to idle periods; an index above four is ignored.
module washer_tick_timer_motor_reversal_core
  import wttmr_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  // configuration write port
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CntW-1:0]     cfg_data_i,
  // tick request channel
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic [1:0]          run_state_i,
  input  logic                rotate_request_i,
  input  logic                high_speed_request_i,
  input  logic                fill_open_i,
  input  logic                drain_request_i,
  input  logic                clear_rotate_i,
  input  logic                clear_fill_i,
  input  logic                clear_drain_i,
  // result channel
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic                motor_on_o,
  output logic                motor_left_o,
  output logic                motor_fast_o,
  output logic [CntW-1:0]     rotate_minutes_o,
  output logic                power_off_request_o,
  output logic                fault_reset_request_o
);

  // Configuration registers
  logic [CntW-1:0] reverse_period_q, ticks_per_minute_q;
  logic [CntW-1:0] idle_limit_q, fill_limit_q, drain_limit_q;

  // Architectural state
  logic [CntW-1:0] tick_q, idle_min_q, fill_min_q, drain_min_q, rot_min_q;
  logic            motor_q, left_q, fast_q, power_off_q, fault_q;
  logic [CntW-1:0] tick_d, idle_min_d, fill_min_d, drain_min_d, rot_min_d;
  logic            motor_d, left_d, fast_d, power_off_d, fault_d;

  // Sequencer
  state_e               state_q, state_d;
  logic [BitCntW-1:0]   bit_cnt_q;
  logic                 out_valid_q, out_valid_d;

  // Captured request
  logic [1:0]      run_q;
  logic            rot_req_q, fast_req_q, fill_req_q, drain_req_q;
  logic            clr_rot_q, clr_fill_q, clr_drain_q;
  logic [CntW-1:0] tick_inc_q;

  // Shared divider unit
  logic [CntW-1:0] dividend_q, rem_q, rem_d;
  logic [CntW:0]   trial;
  logic [CntW-1:0] diff;
  logic            trial_ge;

  logic in_fire, out_fire, commit;
  logic div_last, out_quiet;

  assign in_fire    = in_valid_i && (state_q == ST_IDLE);
  assign out_fire   = out_valid_q && !out_stall_i;
  assign commit     = (state_q == ST_DONE) && (!out_valid_q || !out_stall_i);
  assign in_stall_o = (state_q != ST_IDLE);
  assign div_last   = (state_q == ST_DIV) && (bit_cnt_q == '0);
  assign out_quiet  = !out_valid_q && (state_q != ST_DONE);

  // One restoring-division step: shift in the next dividend bit, subtract
  // the period when it fits.
  assign trial    = {rem_q, dividend_q[CntW-1]};
  assign diff     = trial[CntW-1:0] - reverse_period_q;
  assign trial_ge = (trial >= {1'b0, reverse_period_q});
  assign rem_d    = trial_ge ? diff : trial[CntW-1:0];

  // Sequencer next state
  always_comb begin
    state_d     = state_q;
    out_valid_d = out_valid_q;
    if (out_fire) begin
      out_valid_d = 1'b0;
    end
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          state_d = ST_DIV;
        end
      end
      ST_DIV: begin
        if (bit_cnt_q == '0) begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (commit) begin
          out_valid_d = 1'b1;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Tick update, evaluated on the captured request and the finished remainder
  always_comb begin
    logic            hit;
    logic [CntW-1:0] idle_inc, fill_inc, drain_inc;

    hit = (reverse_period_q == '0) ? (tick_inc_q == '0) : (rem_q == '0);

    // Clears come first
    rot_min_d   = clr_rot_q   ? '0 : rot_min_q;
    fill_min_d  = clr_fill_q  ? '0 : fill_min_q;
    drain_min_d = clr_drain_q ? '0 : drain_min_q;

    tick_d      = tick_q;
    idle_min_d  = idle_min_q;
    motor_d     = motor_q;
    left_d      = left_q;
    fast_d      = fast_q;
    power_off_d = power_off_q;
    fault_d     = fault_q;

    idle_inc  = idle_min_q + 1'b1;
    fill_inc  = fill_min_d + 1'b1;
    drain_inc = drain_min_d + 1'b1;

    if (run_q != RUN_SUSPEND) begin
      tick_d = tick_inc_q;

      // Motor: stop or reverse on the low-speed period, engage high speed right
      if (rot_req_q) begin
        if (!fast_req_q && hit) begin
          if (motor_q) begin
            motor_d = 1'b0;
          end else begin
            left_d  = !left_q;
            motor_d = 1'b1;
          end
        end else if (fast_req_q && !fast_q) begin
          left_d  = 1'b0;
          fast_d  = 1'b1;
          motor_d = 1'b1;
        end else if (!fast_req_q && fast_q) begin
          fast_d = 1'b0;
        end
      end else begin
        motor_d = 1'b0;
      end

      // Minute boundary
      if (tick_inc_q >= ticks_per_minute_q) begin
        tick_d = '0;
        if (run_q == RUN_IDLE) begin
          idle_min_d = idle_inc;
          if (idle_inc >= idle_limit_q) begin
            power_off_d = 1'b1;
          end
        end
        if (fill_req_q) begin
          fill_min_d = fill_inc;
          if (fill_inc >= fill_limit_q) begin
            fault_d = 1'b1;
          end
        end
        if (drain_req_q) begin
          drain_min_d = drain_inc;
          if (drain_inc >= drain_limit_q) begin
            fault_d = 1'b1;
          end
        end
        if (rot_req_q) begin
          rot_min_d = rot_min_d + 1'b1;
        end
      end
    end
  end

  // Control and architectural state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q            <= ST_IDLE;
      out_valid_q        <= 1'b0;
      bit_cnt_q          <= '0;
      reverse_period_q   <= RST_REVERSE_PERIOD;
      ticks_per_minute_q <= RST_TICKS_PER_MINUTE;
      idle_limit_q       <= RST_IDLE_LIMIT;
      fill_limit_q       <= RST_FILL_LIMIT;
      drain_limit_q      <= RST_DRAIN_LIMIT;
      tick_q             <= '0;
      idle_min_q         <= '0;
      fill_min_q         <= '0;
      drain_min_q        <= '0;
      rot_min_q          <= '0;
      motor_q            <= 1'b0;
      left_q             <= 1'b0;
      fast_q             <= 1'b0;
      power_off_q        <= 1'b0;
      fault_q            <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;

      // Load the step count on accept, count down while dividing
      if (in_fire) begin
        bit_cnt_q <= BitCntW'(CntW - 1);
      end else if (state_q == ST_DIV) begin
        bit_cnt_q <= bit_cnt_q - 1'b1;
      end

      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_REVERSE_PERIOD:   reverse_period_q   <= cfg_data_i;
          REG_TICKS_PER_MINUTE: ticks_per_minute_q <= cfg_data_i;
          REG_IDLE_LIMIT:       idle_limit_q       <= cfg_data_i;
          REG_FILL_LIMIT:       fill_limit_q       <= cfg_data_i;
          REG_DRAIN_LIMIT:      drain_limit_q      <= cfg_data_i;
          default: ;
        endcase
      end

      if (commit) begin
        tick_q      <= tick_d;
        idle_min_q  <= idle_min_d;
        fill_min_q  <= fill_min_d;
        drain_min_q <= drain_min_d;
        rot_min_q   <= rot_min_d;
        motor_q     <= motor_d;
        left_q      <= left_d;
        fast_q      <= fast_d;
        power_off_q <= power_off_d;
        fault_q     <= fault_d;
      end
    end
  end

  // Request capture and divider datapath
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      run_q       <= run_state_i;
      rot_req_q   <= rotate_request_i;
      fast_req_q  <= high_speed_request_i;
      fill_req_q  <= fill_open_i;
      drain_req_q <= drain_request_i;
      clr_rot_q   <= clear_rotate_i;
      clr_fill_q  <= clear_fill_i;
      clr_drain_q <= clear_drain_i;
      tick_inc_q  <= tick_q + 1'b1;
      dividend_q  <= tick_q + 1'b1;
      rem_q       <= '0;
    end else if (state_q == ST_DIV) begin
      dividend_q <= {dividend_q[CntW-2:0], 1'b0};
      rem_q      <= rem_d;
    end
  end

  // Result fields come straight from the state registers
  assign out_valid_o           = out_valid_q;
  assign motor_on_o            = motor_q;
  assign motor_left_o          = left_q;
  assign motor_fast_o          = fast_q;
  assign rotate_minutes_o      = rot_min_q;
  assign power_off_request_o   = power_off_q;
  assign fault_reset_request_o = fault_q;

`include "washer_tick_timer_motor_reversal_core_macros.svh"

  `WTTMR_ASSERT_NEXT(a_busy_after_accept, in_fire, state_q == ST_DIV, "divider not started")
  `WTTMR_ASSERT_NEXT(a_div_ends_in_done, div_last, state_q == ST_DONE, "divider did not finish")
  `WTTMR_ASSERT_NEXT(a_result_from_commit, out_quiet, !out_valid_q, "result without commit")

endmodule

// ----- verif/wttmr_tick_checker.sv -----
// ---------------------------------------------------------------------------
// Washer tick timer result checker
// Watches the register write port and both handshake channels, keeps its own
// copy of the timer state and registers, and compares each result request
// with the status predicted for the oldest accepted tick.
// ---------------------------------------------------------------------------
module wttmr_tick_checker
  import wttmr_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_idx_i,
  input  logic [CntW-1:0]    cfg_data_i,
  input  logic               in_valid_i,
  input  logic               in_stall_i,
  input  logic [1:0]         run_state_i,
  input  logic               rotate_request_i,
  input  logic               high_speed_request_i,
  input  logic               fill_open_i,
  input  logic               drain_request_i,
  input  logic               clear_rotate_i,
  input  logic               clear_fill_i,
  input  logic               clear_drain_i,
  input  logic               out_valid_i,
  input  logic               out_stall_i,
  input  logic               motor_on_i,
  input  logic               motor_left_i,
  input  logic               motor_fast_i,
  input  logic [CntW-1:0]    rotate_minutes_i,
  input  logic               power_off_request_i,
  input  logic               fault_reset_request_i,
  output int                 fail_count_o,
  output int                 pending_o,
  output int                 checked_o
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic            power;
    logic            left;
    logic            fast;
    logic [CntW-1:0] rot_min;
    logic            poff;
    logic            fault;
  } tick_status_t;

  tick_status_t status_q[$];

  // register copy
  logic [CntW-1:0] rev_period, ticks_per_min, idle_lim, fill_lim, drain_lim;
  // timer state copy
  logic [CntW-1:0] tick_cnt, idle_min, fill_min, drain_min, rot_min;
  logic            running, dir_left, fast_on, poff_latch, fault_latch;

  // Advance the timer by one tick and queue the status it should report.
  task automatic advance_timer(input logic [1:0] run, input logic rot, input logic fast,
                               input logic fill, input logic drain, input logic clr_rot,
                               input logic clr_fill, input logic clr_drain);
    logic         hit;
    tick_status_t st;
    if (clr_rot) rot_min = '0;
    if (clr_fill) fill_min = '0;
    if (clr_drain) drain_min = '0;
    if (run != RUN_SUSPEND) begin
      tick_cnt = tick_cnt + 1'b1;
      // a zero period behaves as 256
      hit = (rev_period == '0) ? (tick_cnt == '0) : ((tick_cnt % rev_period) == '0);
      if (rot) begin
        if (!fast && hit) begin
          if (running) begin
            running = 1'b0;
          end else begin
            dir_left = !dir_left;
            running  = 1'b1;
          end
        end else if (fast && !fast_on) begin
          dir_left = 1'b0;
          fast_on  = 1'b1;
          running  = 1'b1;
        end else if (!fast && fast_on) begin
          fast_on = 1'b0;
        end
      end else begin
        running = 1'b0;
      end
      if (tick_cnt >= ticks_per_min) begin
        tick_cnt = '0;
        if (run == RUN_IDLE) begin
          idle_min = idle_min + 1'b1;
          if (idle_min >= idle_lim) poff_latch = 1'b1;
        end
        if (fill) begin
          fill_min = fill_min + 1'b1;
          if (fill_min >= fill_lim) fault_latch = 1'b1;
        end
        if (drain) begin
          drain_min = drain_min + 1'b1;
          if (drain_min >= drain_lim) fault_latch = 1'b1;
        end
        if (rot) rot_min = rot_min + 1'b1;
      end
    end
    st.power   = running;
    st.left    = dir_left;
    st.fast    = fast_on;
    st.rot_min = rot_min;
    st.poff    = poff_latch;
    st.fault   = fault_latch;
    status_q.push_back(st);
  endtask

  task automatic check_field(input string field, input int unsigned want,
                             input int unsigned got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
      fail_count_o++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : watch
    tick_status_t want;
    if (!rst_ni) begin
      rev_period    = RST_REVERSE_PERIOD;
      ticks_per_min = RST_TICKS_PER_MINUTE;
      idle_lim      = RST_IDLE_LIMIT;
      fill_lim      = RST_FILL_LIMIT;
      drain_lim     = RST_DRAIN_LIMIT;
      tick_cnt      = '0;
      idle_min      = '0;
      fill_min      = '0;
      drain_min     = '0;
      rot_min       = '0;
      running       = 1'b0;
      dir_left      = 1'b0;
      fast_on       = 1'b0;
      poff_latch    = 1'b0;
      fault_latch   = 1'b0;
      status_q.delete();
    end else begin
      if (out_valid_i && !out_stall_i) begin
        if (status_q.size() == 0) begin
          $display("%0t: result request with no tick outstanding", $time);
          fail_count_o++;
        end else begin
          want = status_q.pop_front();
          check_field("motor_on", 32'(want.power), 32'(motor_on_i));
          check_field("motor_left", 32'(want.left), 32'(motor_left_i));
          check_field("motor_fast", 32'(want.fast), 32'(motor_fast_i));
          check_field("rotate_minutes", 32'(want.rot_min), 32'(rotate_minutes_i));
          check_field("power_off_request", 32'(want.poff), 32'(power_off_request_i));
          check_field("fault_reset_request", 32'(want.fault), 32'(fault_reset_request_i));
          checked_o++;
        end
      end
      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_REVERSE_PERIOD:   rev_period    = cfg_data_i;
          REG_TICKS_PER_MINUTE: ticks_per_min = cfg_data_i;
          REG_IDLE_LIMIT:       idle_lim      = cfg_data_i;
          REG_FILL_LIMIT:       fill_lim      = cfg_data_i;
          REG_DRAIN_LIMIT:      drain_lim     = cfg_data_i;
          default: ;
        endcase
      end
      if (in_valid_i && !in_stall_i) begin
        advance_timer(run_state_i, rotate_request_i, high_speed_request_i, fill_open_i,
                      drain_request_i, clear_rotate_i, clear_fill_i, clear_drain_i);
      end
    end
    pending_o = status_q.size();
  end

endmodule

// ----- verif/testbench.sv -----
// ---------------------------------------------------------------------------
// Washer tick timer testbench
// Drives tick requests through the core under several register settings,
// with random idling on both channels, and takes the verdict from the
// checker that predicts every result request.
// ---------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import wttmr_pkg::*;

  localparam int CLK_PERIOD  = 20;
  localparam int CYCLE_LIMIT = 400000;
  localparam int SETTLE      = 16;
  localparam int NUM_PHASES  = 6;

  // Run state code that the core treats as running.
  localparam logic [1:0] RUN_SPARE = 2'd3;
  // A register index the core must ignore.
  localparam logic [CfgIdxW-1:0] REG_UNUSED = 3'd7;

  typedef struct {
    logic [CntW-1:0] rev_period;
    logic [CntW-1:0] ticks_per_min;
    logic [CntW-1:0] idle_lim;
    logic [CntW-1:0] fill_lim;
    logic [CntW-1:0] drain_lim;
    int              ticks;
    int              clear_pct;
    int              send_pct;
    int              recv_pct;
  } phase_t;

  logic               clk, rst_n;
  logic               cfg_we;
  logic [CfgIdxW-1:0] cfg_idx;
  logic [CntW-1:0]    cfg_data;
  logic               in_valid, in_stall;
  logic [1:0]         run_state;
  logic               rot_req, fast_req, fill_open, drain_req;
  logic               clr_rot, clr_fill, clr_drain;
  logic               out_valid, out_stall;
  logic               motor_on, motor_left, motor_fast;
  logic [CntW-1:0]    rot_minutes;
  logic               power_off, fault_reset;

  int send_idle_pct, recv_idle_pct;
  int cycles, ticks_sent;
  int fail_count, pending, checked;

  // Sticky request fields, so that random ticks form realistic runs.
  logic [1:0] cur_run;
  logic       cur_rot, cur_fast, cur_fill, cur_drain;

  phase_t plan[NUM_PHASES];

  washer_tick_timer_motor_reversal_core DUT (
    .clk_i                 (clk),
    .rst_ni                (rst_n),
    .cfg_we_i              (cfg_we),
    .cfg_idx_i             (cfg_idx),
    .cfg_data_i            (cfg_data),
    .in_valid_i            (in_valid),
    .in_stall_o            (in_stall),
    .run_state_i           (run_state),
    .rotate_request_i      (rot_req),
    .high_speed_request_i  (fast_req),
    .fill_open_i           (fill_open),
    .drain_request_i       (drain_req),
    .clear_rotate_i        (clr_rot),
    .clear_fill_i          (clr_fill),
    .clear_drain_i         (clr_drain),
    .out_valid_o           (out_valid),
    .out_stall_i           (out_stall),
    .motor_on_o            (motor_on),
    .motor_left_o          (motor_left),
    .motor_fast_o          (motor_fast),
    .rotate_minutes_o      (rot_minutes),
    .power_off_request_o   (power_off),
    .fault_reset_request_o (fault_reset)
  );

  wttmr_tick_checker tick_monitor (
    .clk_i                 (clk),
    .rst_ni                (rst_n),
    .cfg_we_i              (cfg_we),
    .cfg_idx_i             (cfg_idx),
    .cfg_data_i            (cfg_data),
    .in_valid_i            (in_valid),
    .in_stall_i            (in_stall),
    .run_state_i           (run_state),
    .rotate_request_i      (rot_req),
    .high_speed_request_i  (fast_req),
    .fill_open_i           (fill_open),
    .drain_request_i       (drain_req),
    .clear_rotate_i        (clr_rot),
    .clear_fill_i          (clr_fill),
    .clear_drain_i         (clr_drain),
    .out_valid_i           (out_valid),
    .out_stall_i           (out_stall),
    .motor_on_i            (motor_on),
    .motor_left_i          (motor_left),
    .motor_fast_i          (motor_fast),
    .rotate_minutes_i      (rot_minutes),
    .power_off_request_i   (power_off),
    .fault_reset_request_i (fault_reset),
    .fail_count_o          (fail_count),
    .pending_o             (pending),
    .checked_o             (checked)
  );

  initial begin
    clk = 1'b0;
    forever #(CLK_PERIOD / 2) clk = ~clk;
  end

  // Stop a hung run: count cycles and fail once the limit is passed.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles with %0d results outstanding", cycles, pending);
      $display("testbench failed");
      $finish;
    end
  end

  // Receiver: stall at random, at the rate of the current phase.
  always @(posedge clk) begin
    if (!rst_n) out_stall <= 1'b0;
    else        out_stall <= ($urandom_range(99) < recv_idle_pct);
  end

  // Offer one tick request and hold it until accepted. An idle stretch, if
  // drawn, drops valid first so that it never falls and rises in one step.
  task automatic send_tick(input logic [1:0] run, input logic rot, input logic fast,
                           input logic fill, input logic drain, input logic cr,
                           input logic cf, input logic cd);
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    in_valid  <= 1'b1;
    run_state <= run;
    rot_req   <= rot;
    fast_req  <= fast;
    fill_open <= fill;
    drain_req <= drain;
    clr_rot   <= cr;
    clr_fill  <= cf;
    clr_drain <= cd;
    do @(posedge clk); while (in_stall);
    ticks_sent++;
  endtask

  // Hold off the sender until every predicted result has been taken.
  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(negedge clk); while (pending != 0);
    @(posedge clk);
  endtask

  // Write all five registers plus one index the core must ignore.
  task automatic program_regs(input phase_t p);
    cfg_we <= 1'b1;
    cfg_idx <= REG_REVERSE_PERIOD;   cfg_data <= p.rev_period;    @(posedge clk);
    cfg_idx <= REG_TICKS_PER_MINUTE; cfg_data <= p.ticks_per_min; @(posedge clk);
    cfg_idx <= REG_IDLE_LIMIT;       cfg_data <= p.idle_lim;      @(posedge clk);
    cfg_idx <= REG_FILL_LIMIT;       cfg_data <= p.fill_lim;      @(posedge clk);
    cfg_idx <= REG_DRAIN_LIMIT;      cfg_data <= p.drain_lim;     @(posedge clk);
    cfg_idx <= REG_UNUSED;           cfg_data <= 8'($urandom());  @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // Random ticks: mostly sticky runs of requests with random clears, plus
  // some fully random noise. Drain the pipe once halfway through.
  task automatic random_ticks(input int count, input int clear_pct);
    int r;
    for (int i = 0; i < count; i++) begin
      if (i == count / 2) wait_drained();
      if ($urandom_range(9) == 0) begin
        r = $urandom_range(9);
        if (r < 5)       cur_run = RUN_ACTIVE;
        else if (r < 7)  cur_run = RUN_IDLE;
        else if (r < 9)  cur_run = RUN_SUSPEND;
        else             cur_run = RUN_SPARE;
      end
      if ($urandom_range(7) == 0)  cur_rot   = ($urandom_range(99) < 90);
      if ($urandom_range(11) == 0) cur_fast  = ($urandom_range(3) == 0);
      if ($urandom_range(7) == 0)  cur_fill  = 1'($urandom_range(1));
      if ($urandom_range(7) == 0)  cur_drain = 1'($urandom_range(1));
      if ($urandom_range(15) == 0) begin
        send_tick(2'($urandom_range(3)), 1'($urandom_range(1)), 1'($urandom_range(1)),
                  1'($urandom_range(1)), 1'($urandom_range(1)), 1'($urandom_range(1)),
                  1'($urandom_range(1)), 1'($urandom_range(1)));
      end else begin
        send_tick(cur_run, cur_rot, cur_fast, cur_fill, cur_drain,
                  ($urandom_range(99) < clear_pct), ($urandom_range(99) < clear_pct),
                  ($urandom_range(99) < clear_pct));
      end
    end
  endtask

  initial begin
    // Drive every input to a known value before the first edge.
    rst_n         = 1'b0;
    cfg_we        = 1'b0;
    cfg_idx       = REG_REVERSE_PERIOD;
    cfg_data      = '0;
    in_valid      = 1'b0;
    run_state     = RUN_ACTIVE;
    rot_req       = 1'b0;
    fast_req      = 1'b0;
    fill_open     = 1'b0;
    drain_req     = 1'b0;
    clr_rot       = 1'b0;
    clr_fill      = 1'b0;
    clr_drain     = 1'b0;
    ticks_sent    = 0;
    send_idle_pct = 0;
    recv_idle_pct = 0;
    cur_run       = RUN_ACTIVE;
    cur_rot       = 1'b1;
    cur_fast      = 1'b0;
    cur_fill      = 1'b0;
    cur_drain     = 1'b0;

    // Settings run from short minutes with latches out of reach, through the
    // register extremes, to tight limits that set both latches. The no-clear
    // phases count a minute on every tick.
    plan[0] = '{8'd2, 8'd3, 8'd255, 8'd255, 8'd255, 120, 5, 35, 54};
    plan[1] = '{8'd5, 8'd12, 8'd200, 8'd200, 8'd200, 120, 5, 35, 54};
    plan[2] = '{8'd0, 8'd255, 8'd255, 8'd255, 8'd255, 120, 5, 54, 35};
    plan[3] = '{8'd1, 8'd0, 8'd30, 8'd40, 8'd25, 200, 0, 54, 35};
    plan[4] = '{8'd255, 8'd1, 8'd0, 8'd1, 8'd0, 200, 0, 0, 0};
    plan[5] = '{8'($urandom_range(1, 8)), 8'($urandom_range(1, 6)),
                8'($urandom_range(1, 255)), 8'($urandom_range(1, 255)),
                8'($urandom_range(1, 255)), 140, 5, 0, 0};

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // A few ticks under the reset register values, one per run state.
    send_tick(RUN_ACTIVE, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0);
    send_tick(RUN_IDLE, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0);
    send_tick(RUN_SUSPEND, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0);
    wait_drained();
    repeat (SETTLE) @(posedge clk);
    program_regs(plan[0]);

    // Directed ticks: reversal, high-speed engage and its kept flag with
    // rotation off, the spare run state, suspended ticks that only clear,
    // minutes on every counter, and all fields at their extremes.
    send_tick(RUN_ACTIVE, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0);
    send_tick(RUN_ACTIVE, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0);
    send_tick(RUN_ACTIVE, 1'b1, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0);
    send_tick(RUN_ACTIVE, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0);
    send_tick(RUN_ACTIVE, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0);
    send_tick(RUN_ACTIVE, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0);
    send_tick(RUN_SPARE, 1'b1, 1'b0, 1'b1, 1'b1, 1'b0, 1'b0, 1'b0);
    send_tick(RUN_SPARE, 1'b1, 1'b0, 1'b1, 1'b1, 1'b0, 1'b0, 1'b0);
    send_tick(RUN_IDLE, 1'b1, 1'b0, 1'b1, 1'b1, 1'b0, 1'b0, 1'b0);
    send_tick(RUN_IDLE, 1'b1, 1'b0, 1'b1, 1'b1, 1'b0, 1'b0, 1'b0);
    send_tick(RUN_SUSPEND, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1);
    send_tick(RUN_SUSPEND, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0);
    send_tick(RUN_IDLE, 1'b1, 1'b0, 1'b1, 1'b1, 1'b0, 1'b0, 1'b0);
    send_tick(RUN_ACTIVE, 1'b1, 1'b0, 1'b0, 1'b0, 1'b1, 1'b1, 1'b1);
    send_tick(RUN_SPARE, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1);
    send_tick(RUN_ACTIVE, 1'b1, 1'b1, 1'b1, 1'b1, 1'b0, 1'b0, 1'b0);
    send_tick(RUN_ACTIVE, 1'b1, 1'b0, 1'b1, 1'b1, 1'b0, 1'b0, 1'b0);

    // Random phases; registers change only once the pipe is empty.
    for (int p = 0; p < NUM_PHASES; p++) begin
      if (p != 0) begin
        wait_drained();
        repeat (SETTLE) @(posedge clk);
        program_regs(plan[p]);
      end
      send_idle_pct = plan[p].send_pct;
      recv_idle_pct = plan[p].recv_pct;
      random_ticks(plan[p].ticks, plan[p].clear_pct);
    end

    // Let the last results out, then give the verdict.
    wait_drained();
    repeat (SETTLE) @(posedge clk);
    $display("%0d ticks over %0d register settings, %0d results compared",
             ticks_sent, NUM_PHASES + 1, checked);
    $display("latches at end: power-off %0b, fault-reset %0b", power_off, fault_reset);
    if (fail_count == 0) begin
      $display("testbench passed");
    end else begin
      $display("%0d mismatches", fail_count);
      $display("testbench failed");
    end
    $finish;
  end

endmodule
